>>> sv/fslg_pkg.sv
// fslg_pkg: shared types and constants of the fault supervisor / led gate
// holds the configuration bundle, the result record and register indexes
// no dependencies
package fslg_pkg;

   // sample and register widths
   localparam int VOLT_W      = 16;
   localparam int TEMP_W      = 16;
   localparam int THYST_W     = 15;
   localparam int PERIOD_W    = 16;
   localparam int NOW_W       = 32;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int REQ_DATA_W  = 64;
   localparam int RSP_DATA_W  = 8;

   // default time stamp width, 16 to 32
   localparam int TIME_BITS_DEF = 32;

   // reset value of the undervoltage trip delay in ms
   localparam logic [PERIOD_W-1:0] TRIP_DELAY_RST = 16'd100;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LOW_VOLT_LIMIT  = 3'd0,
      CSR_VOLT_HYST       = 3'd1,
      CSR_VOLT_TRIP_DELAY = 3'd2,
      CSR_TEMP_HIGH       = 3'd3,
      CSR_TEMP_HYST       = 3'd4,
      CSR_TEMP_BLINK      = 3'd5,
      CSR_VOLT_BLINK      = 3'd6,
      CSR_SIGNAL_BLINK    = 3'd7
   } csr_index_type;

   // configuration bundle
   typedef struct packed {
      logic [VOLT_W-1:0]          low_voltage_limit;
      logic [VOLT_W-1:0]          voltage_hysteresis;
      logic [PERIOD_W-1:0]        voltage_trip_delay;
      logic signed [TEMP_W-1:0]   temperature_high;
      logic [THYST_W-1:0]         temperature_hysteresis;
      logic [PERIOD_W-1:0]        temp_blink_period;
      logic [PERIOD_W-1:0]        volt_blink_period;
      logic [PERIOD_W-1:0]        signal_blink_period;
   } cfg_type;

   // result record, last member lands in bit 0
   typedef struct packed {
      logic servo_start_pulse;
      logic stop_pulse;
      logic outputs_enabled;
      logic green_led;
      logic red_led;
      logic link_fault;
      logic undervoltage_fault;
      logic overtemp_fault;
   } result_type;

   // register values after reset: all zero except the trip delay
   function automatic cfg_type cfg_reset_value();
      cfg_type c;
      c = '0;
      c.voltage_trip_delay = TRIP_DELAY_RST;
      return c;
   endfunction

endpackage

>>> sv/fslg_csr.sv
// fslg_csr: configuration register file of the fault supervisor
// decodes register writes into the cfg_type bundle; uses fslg_pkg
module fslg_csr
   import fslg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [CSR_IDX_W-1:0]   wr_index,
   input  logic [CSR_DATA_W-1:0]  wr_data,
   output cfg_type                cfg
);

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // register write decode
   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (csr_index_type'(wr_index))
            CSR_LOW_VOLT_LIMIT:  cfg_in.low_voltage_limit      = wr_data;
            CSR_VOLT_HYST:       cfg_in.voltage_hysteresis     = wr_data;
            CSR_VOLT_TRIP_DELAY: cfg_in.voltage_trip_delay     = wr_data;
            CSR_TEMP_HIGH:       cfg_in.temperature_high       = wr_data;
            CSR_TEMP_HYST:       cfg_in.temperature_hysteresis = wr_data[THYST_W-1:0];
            CSR_TEMP_BLINK:      cfg_in.temp_blink_period      = wr_data;
            CSR_VOLT_BLINK:      cfg_in.volt_blink_period      = wr_data;
            CSR_SIGNAL_BLINK:    cfg_in.signal_blink_period    = wr_data;
            default:             cfg_in = cfg_ff;
         endcase
      end
   end

   // register storage
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= cfg_reset_value();
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

>>> sv/fslg_core.sv
// fslg_core: fault evaluation, led selection and output gate for one sample
// holds the supervisor state, updated once per sample; uses fslg_pkg
module fslg_core
   import fslg_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  cfg_type                  cfg,
   input  logic                     step,
   input  logic [TIME_BITS-1:0]     now,
   input  logic [VOLT_W-1:0]        volt,
   input  logic signed [TEMP_W-1:0] temp,
   input  logic                     lost,
   output result_type               result
);

   logic                  low_pending_ff, low_pending_in;
   logic [TIME_BITS-1:0]  low_start_ff, low_start_in;
   logic                  volt_fault_ff, volt_fault_in;
   logic                  temp_fault_ff, temp_fault_in;
   logic                  prev_any_ff, prev_any_in;
   logic [TIME_BITS-1:0]  blink_time_ff, blink_time_in;
   logic                  red_ff, red_in;
   logic                  green_ff, green_in;

   logic [TIME_BITS-1:0]     low_elapsed;
   logic [TIME_BITS-1:0]     blink_elapsed;
   logic [VOLT_W:0]          volt_clear;
   logic signed [TEMP_W:0]   temp_clear;
   logic [PERIOD_W-1:0]      period;
   logic                     blink_due;
   logic                     any_fault;

   // elapsed times wrap with the stamp width
   assign low_elapsed   = now - low_start_ff;
   assign blink_elapsed = now - blink_time_ff;

   // clear levels in one extra bit so they cannot wrap
   assign volt_clear = {1'b0, cfg.low_voltage_limit} + {1'b0, cfg.voltage_hysteresis};
   assign temp_clear = {cfg.temperature_high[TEMP_W-1], cfg.temperature_high}
                       - $signed({2'b00, cfg.temperature_hysteresis});

   // undervoltage: arm, then trip after the delay, clear at or above limit plus hysteresis
   always_comb begin
      low_pending_in = low_pending_ff;
      low_start_in   = low_start_ff;
      volt_fault_in  = volt_fault_ff;
      if (!low_pending_ff) begin
         if (volt <= cfg.low_voltage_limit) begin
            low_pending_in = 1'b1;
            low_start_in   = now;
         end
      end else if ({1'b0, volt} >= volt_clear) begin
         low_pending_in = 1'b0;
         volt_fault_in  = 1'b0;
      end else if (TIME_BITS'(cfg.voltage_trip_delay) <= low_elapsed) begin
         volt_fault_in = 1'b1;
      end
   end

   // over-temperature with hysteresis
   always_comb begin
      temp_fault_in = temp_fault_ff;
      if (!temp_fault_ff) begin
         if (temp >= cfg.temperature_high) begin
            temp_fault_in = 1'b1;
         end
      end else if ($signed({temp[TEMP_W-1], temp}) <= temp_clear) begin
         temp_fault_in = 1'b0;
      end
   end

   // blink period of the fault with highest priority
   always_comb begin
      if (temp_fault_in) begin
         period = cfg.temp_blink_period;
      end else if (volt_fault_in) begin
         period = cfg.volt_blink_period;
      end else begin
         period = cfg.signal_blink_period;
      end
   end

   assign blink_due = TIME_BITS'(period) <= blink_elapsed;

   // led state by priority
   always_comb begin
      red_in        = red_ff;
      green_in      = green_ff;
      blink_time_in = blink_time_ff;
      if (temp_fault_in || volt_fault_in) begin
         green_in = 1'b0;
         if (blink_due) begin
            red_in        = !red_ff;
            blink_time_in = now;
         end
      end else if (lost) begin
         red_in = 1'b0;
         if (blink_due) begin
            green_in      = !green_ff;
            blink_time_in = now;
         end
      end else begin
         red_in   = 1'b0;
         green_in = 1'b1;
      end
   end

   // output gate and edge pulses
   assign any_fault   = temp_fault_in || volt_fault_in || lost;
   assign prev_any_in = any_fault;

   always_comb begin
      result.overtemp_fault     = temp_fault_in;
      result.undervoltage_fault = volt_fault_in;
      result.link_fault         = lost;
      result.red_led            = red_in;
      result.green_led          = green_in;
      result.outputs_enabled    = !any_fault;
      result.stop_pulse         = any_fault && !prev_any_ff;
      result.servo_start_pulse  = !any_fault && prev_any_ff;
   end

   // supervisor state, advanced once per processed sample
   always_ff @(posedge clock) begin
      if (reset) begin
         low_pending_ff <= 1'b0;
         low_start_ff   <= '0;
         volt_fault_ff  <= 1'b0;
         temp_fault_ff  <= 1'b0;
         prev_any_ff    <= 1'b1;
         blink_time_ff  <= '0;
         red_ff         <= 1'b0;
         green_ff       <= 1'b0;
      end else if (step) begin
         low_pending_ff <= low_pending_in;
         low_start_ff   <= low_start_in;
         volt_fault_ff  <= volt_fault_in;
         temp_fault_ff  <= temp_fault_in;
         prev_any_ff    <= prev_any_in;
         blink_time_ff  <= blink_time_in;
         red_ff         <= red_in;
         green_ff       <= green_in;
      end
   end

endmodule

>>> sv/fault_supervisor_led_gate_unit.sv
// fault_supervisor_led_gate_unit: top level of the fault supervisor / led gate
// instantiates fslg_csr and fslg_core; uses fslg_pkg
//
// Each sample transfer (time stamp, battery voltage, die temperature, link
// lost flag) yields exactly one status transfer with the three fault flags,
// the red/green led drive, output enable and the stop / servo start pulses.
// A sample is held in an input register, evaluated combinationally against the
// supervisor state and registered in the result register; one sample is taken
// per cycle, bounded only by the result channel's ready. Time stamps are used
// modulo 2^TIME_BITS. Configuration writes are always accepted and take effect
// from the next sample; write them only while no sample is in flight.
module fault_supervisor_led_gate_unit
   import fslg_pkg::*;
#(
   parameter int TIME_BITS = TIME_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   // sample channel
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // now_ms[31:0], battery_voltage[47:32], die_temperature[63:48]
   input  logic [REQ_DATA_W-1:0]  req_tdata,
   // signal_lost[0]
   input  logic                   req_tuser,
   // status channel
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // overtemp_fault[0], undervoltage_fault[1], link_fault[2], red_led[3],
   // green_led[4], outputs_enabled[5], stop_pulse[6], servo_start_pulse[7]
   output logic [RSP_DATA_W-1:0]  rsp_tdata,
   // configuration write channel
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type cfg;

   logic                     in_valid_ff;
   logic [TIME_BITS-1:0]     in_now_ff;
   logic [VOLT_W-1:0]        in_volt_ff;
   logic signed [TEMP_W-1:0] in_temp_ff;
   logic                     in_lost_ff;

   logic        out_valid_ff;
   result_type  out_ff;
   result_type  result;

   logic out_free;
   logic advance;

   // configuration writes never stall
   assign csr_ready = 1'b1;

   fslg_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (csr_valid),
      .wr_index (csr_index),
      .wr_data  (csr_data),
      .cfg      (cfg)
   );

   // flow control between input and result registers
   assign out_free   = !out_valid_ff || rsp_tready;
   assign advance    = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_now_ff  <= req_tdata[TIME_BITS-1:0];
         in_volt_ff <= req_tdata[NOW_W +: VOLT_W];
         in_temp_ff <= req_tdata[NOW_W+VOLT_W +: TEMP_W];
         in_lost_ff <= req_tuser;
      end
   end

   fslg_core #(
      .TIME_BITS (TIME_BITS)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .step   (advance),
      .now    (in_now_ff),
      .volt   (in_volt_ff),
      .temp   (in_temp_ff),
      .lost   (in_lost_ff),
      .result (result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;

endmodule

>>> sv/fslg_checker.sv
// fslg_checker: port level checks of the fault supervisor / led gate
// bound to fault_supervisor_led_gate_unit; uses fslg_pkg
module fslg_checker
   import fslg_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   input  logic [RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled status transfer holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("status transfer changed while stalled");

   // output enable is the inverse of any fault
   a_enable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[5] == !(rsp_tdata[0] || rsp_tdata[1] || rsp_tdata[2]))
      else $error("output enable disagrees with fault flags");

   // stop and servo start pulses are exclusive, stop only with a fault
   a_pulses: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[6] && rsp_tdata[7]) && !(rsp_tdata[6] && rsp_tdata[5]))
      else $error("edge pulses inconsistent");

   // temperature or voltage fault keeps green dark
   a_green_dark: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[0] || rsp_tdata[1]) |-> !rsp_tdata[4])
      else $error("green lit during red fault");

   // with no fault, steady green and no red
   a_no_fault: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[5] |-> rsp_tdata[4] && !rsp_tdata[3])
      else $error("led pattern wrong without fault");

endmodule

bind fault_supervisor_led_gate_unit fslg_checker u_fslg_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

>>> tb/sv/fault_supervisor_led_gate_unit_tb.sv
`timescale 1ns / 1ps
// fault_supervisor_led_gate_unit_tb: self-checking bench for the fault supervisor / led gate
// drives sample and csr transfers, checks every status transfer against the model or a typed-in value; uses fslg_pkg
module fault_supervisor_led_gate_unit_tb;
   import fslg_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 6;
   localparam int LONG_HOLD    = 300;
   localparam int PHASES       = 6;
   localparam int PHASE_ITEMS  = 255;
   localparam int PROBE_ROWS   = 22;
   localparam int RECONFIG_AT  = 4;
   localparam int CSR_COUNT    = 2 ** CSR_IDX_W;
   localparam int REPORT_MAX   = 10;

   typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_type;

   // one directed sample, optionally with its status typed in
   typedef struct {
      logic [31:0] now;
      logic [15:0] volt;
      logic [15:0] temp;
      logic        lost;
      logic        pinned;
      logic [7:0]  pin;
   } probe_row_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_DATA_W-1:0]  req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_IDX_W-1:0]   csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_data = '0;

   // typed-in status travels with its sample
   logic                   pin_valid = 1'b0;
   result_type             pin_value = '0;

   idle_mode_type          idle_mode = IDLE_NONE;
   bit                     long_hold_req = 1'b0;
   bit                     long_hold_done = 1'b0;
   int                     hold_cycles = 0;
   int                     mismatch_count = 0;
   int                     status_seen = 0;
   int                     cycle_count = 0;

   result_type             status_due[$];

   // supervisor model state and its copy of the registers
   cfg_type                cfg_model;
   logic                   uv_pending, uv_fault, ot_fault, fault_prev, red_on, green_on;
   logic [31:0]            uv_since, blink_at;

   string field_names[RSP_DATA_W] = '{"overtemp_fault", "undervoltage_fault", "link_fault",
      "red_led", "green_led", "outputs_enabled", "stop_pulse", "servo_start_pulse"};

   probe_row_type probe_rows[PROBE_ROWS] = '{
      '{32'd0,          16'd1000,  -16'sd100,   1'b0, 1'b1, 8'b1011_0000},
      '{32'd1,          16'd1000,  -16'sd100,   1'b1, 1'b1, 8'b0100_0100},
      '{32'd2,          16'hFFFF,  16'h7FFF,    1'b0, 1'b1, 8'b0000_1001},
      '{32'd3,          16'hFFFF,  16'h8000,    1'b0, 1'b1, 8'b1011_0000},
      '{32'd100,        16'd900,   16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd100,        16'd900,   16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd103,        16'd1100,  16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd108,        16'd1200,  16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd110,        16'd1500,  16'd50,      1'b0, 1'b0, 8'h00},
      '{32'd113,        16'd1500,  16'd41,      1'b0, 1'b0, 8'h00},
      '{32'd120,        16'd1500,  16'd40,      1'b0, 1'b0, 8'h00},
      '{32'd121,        16'd1500,  16'd0,       1'b1, 1'b0, 8'h00},
      '{32'd128,        16'd1500,  16'd0,       1'b1, 1'b0, 8'h00},
      '{32'hFFFF_FFFE,  16'd1500,  16'd0,       1'b1, 1'b0, 8'h00},
      '{32'd5,          16'd1500,  16'd0,       1'b1, 1'b0, 8'h00},
      '{32'd6,          16'd1500,  16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd7,          16'd0,     16'h8000,    1'b0, 1'b0, 8'h00},
      '{32'd20,         16'd0,     16'h7FFF,    1'b1, 1'b0, 8'h00},
      '{32'd21,         16'hFFFF,  16'h7FFF,    1'b1, 1'b0, 8'h00},
      '{32'hFFFF_FFFF,  16'hFFFF,  16'h8000,    1'b0, 1'b0, 8'h00},
      '{32'd0,          16'd1199,  16'd0,       1'b0, 1'b0, 8'h00},
      '{32'd0,          16'd1000,  16'd0,       1'b1, 1'b0, 8'h00}
   };

   fault_supervisor_led_gate_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #1 clock = ~clock;

   // one supervisor update: advances the model state, returns the status
   function automatic result_type supervise_sample(input logic [31:0] now,
         input logic [15:0] volt, input logic [15:0] temp, input logic lost);
      result_type  st;
      logic        any_fault;
      logic [31:0] blink_dt;
      int          temp_now, temp_clear;
      st = '0;
      temp_now = int'($signed(temp));
      temp_clear = int'($signed(cfg_model.temperature_high))
                   - int'(cfg_model.temperature_hysteresis);

      // undervoltage: arm on a low sample, trip after the delay, clear at or above limit + margin
      if (!uv_pending) begin
         if (volt <= cfg_model.low_voltage_limit) begin
            uv_pending = 1'b1;
            uv_since = now;
         end
      end else if ({1'b0, volt} >= {1'b0, cfg_model.low_voltage_limit}
                   + {1'b0, cfg_model.voltage_hysteresis}) begin
         uv_pending = 1'b0;
         uv_fault = 1'b0;
      end else if ({16'b0, cfg_model.voltage_trip_delay} <= now - uv_since) begin
         uv_fault = 1'b1;
      end

      // over-temperature with hysteresis, clear level never wraps
      if (!ot_fault) begin
         if (temp_now >= int'($signed(cfg_model.temperature_high))) ot_fault = 1'b1;
      end else if (temp_now <= temp_clear) begin
         ot_fault = 1'b0;
      end

      // led by priority: temperature, voltage, link
      blink_dt = now - blink_at;
      if (ot_fault) begin
         green_on = 1'b0;
         if ({16'b0, cfg_model.temp_blink_period} <= blink_dt) begin
            red_on = ~red_on;
            blink_at = now;
         end
      end else if (uv_fault) begin
         green_on = 1'b0;
         if ({16'b0, cfg_model.volt_blink_period} <= blink_dt) begin
            red_on = ~red_on;
            blink_at = now;
         end
      end else if (lost) begin
         red_on = 1'b0;
         if ({16'b0, cfg_model.signal_blink_period} <= blink_dt) begin
            green_on = ~green_on;
            blink_at = now;
         end
      end else begin
         red_on = 1'b0;
         green_on = 1'b1;
      end

      // output gate and edge pulses
      any_fault = ot_fault | uv_fault | lost;
      st.overtemp_fault     = ot_fault;
      st.undervoltage_fault = uv_fault;
      st.link_fault         = lost;
      st.red_led            = red_on;
      st.green_led          = green_on;
      st.outputs_enabled    = ~any_fault;
      st.stop_pulse         = any_fault & ~fault_prev;
      st.servo_start_pulse  = ~any_fault & fault_prev;
      fault_prev = any_fault;
      return st;
   endfunction

   // model update on every csr and sample transfer
   always @(posedge clock) begin
      result_type st;
      if (reset) begin
         cfg_model = '0;
         cfg_model.voltage_trip_delay = TRIP_DELAY_RST;
         uv_pending = 1'b0;
         uv_since   = '0;
         uv_fault   = 1'b0;
         ot_fault   = 1'b0;
         fault_prev = 1'b1;
         blink_at   = '0;
         red_on     = 1'b0;
         green_on   = 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_LOW_VOLT_LIMIT:  cfg_model.low_voltage_limit = csr_data;
               CSR_VOLT_HYST:       cfg_model.voltage_hysteresis = csr_data;
               CSR_VOLT_TRIP_DELAY: cfg_model.voltage_trip_delay = csr_data;
               CSR_TEMP_HIGH:       cfg_model.temperature_high = csr_data;
               CSR_TEMP_HYST:       cfg_model.temperature_hysteresis = csr_data[THYST_W-1:0];
               CSR_TEMP_BLINK:      cfg_model.temp_blink_period = csr_data;
               CSR_VOLT_BLINK:      cfg_model.volt_blink_period = csr_data;
               CSR_SIGNAL_BLINK:    cfg_model.signal_blink_period = csr_data;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            st = supervise_sample(req_tdata[31:0], req_tdata[47:32], req_tdata[63:48],
                                  req_tuser);
            status_due.push_back(pin_valid ? pin_value : st);
         end
      end
   end

   // long receiver hold, counted in its own process
   always @(posedge clock) begin
      if (long_hold_req && !long_hold_done) begin
         hold_cycles <= hold_cycles + 1;
         if (hold_cycles + 1 >= LONG_HOLD) long_hold_done <= 1'b1;
      end
   end

   // status check and receiver ready pattern
   always @(posedge clock) begin
      result_type want;
      int stall_pct;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (status_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("status %0d: unexpected transfer %b", status_seen, rsp_tdata);
         end else begin
            want = status_due.pop_front();
            if (rsp_tdata !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  for (int b = 0; b < RSP_DATA_W; b++)
                     if (rsp_tdata[b] !== want[b])
                        $display("status %0d: %s expected %b got %b", status_seen,
                                 field_names[b], want[b], rsp_tdata[b]);
            end
         end
         status_seen++;
      end
      case (idle_mode)
         IDLE_RECV: stall_pct = 55;
         IDLE_BOTH: stall_pct = 16;
         default:   stall_pct = 0;
      endcase
      if (long_hold_req && !long_hold_done) begin
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("== FAIL ==");
         $finish;
      end
   end

   // wait until every status has come back and the pipeline is empty
   task automatic drain_results();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (status_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // write all registers while the block is idle
   task automatic apply_cfg(input cfg_type c);
      logic [CSR_DATA_W-1:0] v;
      drain_results();
      for (int i = 0; i < CSR_COUNT; i++) begin
         case (csr_index_type'(i))
            CSR_LOW_VOLT_LIMIT:  v = c.low_voltage_limit;
            CSR_VOLT_HYST:       v = c.voltage_hysteresis;
            CSR_VOLT_TRIP_DELAY: v = c.voltage_trip_delay;
            CSR_TEMP_HIGH:       v = c.temperature_high;
            CSR_TEMP_HYST:       v = {1'($urandom_range(1)), c.temperature_hysteresis};
            CSR_TEMP_BLINK:      v = c.temp_blink_period;
            CSR_VOLT_BLINK:      v = c.volt_blink_period;
            default:             v = c.signal_blink_period;
         endcase
         csr_valid <= 1'b1;
         csr_index <= csr_index_type'(i);
         csr_data  <= v;
         do @(posedge clock); while (!csr_ready);
      end
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // offer one sample, with random idle cycles ahead of it
   task automatic send_sample(input logic [31:0] now, input logic [15:0] volt,
         input logic [15:0] temp, input logic lost, input logic pinned, input result_type pin);
      int idle_pct;
      case (idle_mode)
         IDLE_SEND: idle_pct = 55;
         IDLE_BOTH: idle_pct = 16;
         default:   idle_pct = 0;
      endcase
      while ($urandom_range(99) < idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {temp, volt, now};
      req_tuser  <= lost;
      pin_valid  <= pinned;
      pin_value  <= pin;
      do @(posedge clock); while (!req_tready);
   endtask

   initial begin
      cfg_type        c;
      idle_mode_type  phase_modes[PHASES];
      logic [31:0]    t_now;
      logic           lost_run;
      int             span, lim, hy, th, thy, vb, tv;

      phase_modes = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed samples: reset values first, then a mid-range setting
      for (int i = 0; i < PROBE_ROWS; i++) begin
         if (i == RECONFIG_AT) begin
            c = '0;
            c.low_voltage_limit      = 16'd1000;
            c.voltage_hysteresis     = 16'd200;
            c.voltage_trip_delay     = 16'd0;
            c.temperature_high       = 16'sd50;
            c.temperature_hysteresis = 15'd10;
            c.temp_blink_period      = 16'd3;
            c.volt_blink_period      = 16'd5;
            c.signal_blink_period    = 16'd7;
            apply_cfg(c);
         end
         send_sample(probe_rows[i].now, probe_rows[i].volt, probe_rows[i].temp,
                     probe_rows[i].lost, probe_rows[i].pinned, probe_rows[i].pin);
      end

      // random phases, each with its own setting and idle pattern
      t_now = $urandom;
      lost_run = 1'b0;
      for (int p = 0; p < PHASES; p++) begin
         if (p == 0) begin
            c = '0;
         end else if (p == PHASES - 1) begin
            c = '1;
            c.temperature_high = 16'sh7FFF;
         end else begin
            c.low_voltage_limit      = 16'($urandom_range(65535));
            c.voltage_hysteresis     = 16'($urandom_range(300));
            c.voltage_trip_delay     = 16'($urandom_range(40));
            c.temperature_high       = 16'($urandom);
            c.temperature_hysteresis = 15'($urandom_range(200));
            c.temp_blink_period      = 16'($urandom_range(12));
            c.volt_blink_period      = 16'($urandom_range(12));
            c.signal_blink_period    = 16'($urandom_range(12));
            // temperature clear level far below the sample range
            if (p == 1) begin
               c.temperature_high       = 16'sh8000;
               c.temperature_hysteresis = 15'h7FFF;
            end
         end
         apply_cfg(c);
         idle_mode = phase_modes[p];
         if (p == 4) long_hold_req = 1'b1;

         lim  = int'(c.low_voltage_limit);
         hy   = int'(c.voltage_hysteresis);
         th   = int'($signed(c.temperature_high));
         thy  = int'(c.temperature_hysteresis);
         span = int'(c.voltage_trip_delay);
         if (int'(c.temp_blink_period) > span) span = int'(c.temp_blink_period);
         if (int'(c.volt_blink_period) > span) span = int'(c.volt_blink_period);
         if (int'(c.signal_blink_period) > span) span = int'(c.signal_blink_period);
         span = span / 4 + 3;

         for (int k = 0; k < PHASE_ITEMS; k++) begin
            // time mostly moves forward in small steps, now and then it jumps
            if ($urandom_range(99) < 3) t_now = $urandom;
            else t_now = t_now + $urandom_range(span);
            if ($urandom_range(99) < 10) lost_run = ~lost_run;

            if ($urandom_range(99) < 15) begin
               // noise
               send_sample(t_now, 16'($urandom), 16'($urandom), 1'($urandom_range(1)),
                           1'b0, '0);
            end else begin
               // voltage and temperature close to their thresholds
               case ($urandom_range(3))
                  0:       vb = lim - int'($urandom_range(8));
                  1:       vb = lim + int'($urandom_range(8));
                  2:       vb = lim + hy - int'($urandom_range(8));
                  default: vb = lim + hy + int'($urandom_range(8));
               endcase
               if (vb < 0) vb = 0;
               else if (vb > 65535) vb = 65535;
               case ($urandom_range(3))
                  0:       tv = th - int'($urandom_range(8));
                  1:       tv = th + int'($urandom_range(8));
                  2:       tv = th - thy - int'($urandom_range(8));
                  default: tv = th - thy + int'($urandom_range(8));
               endcase
               if (tv < -32768) tv = -32768;
               else if (tv > 32767) tv = 32767;
               send_sample(t_now, vb[15:0], tv[15:0], lost_run, 1'b0, '0);
            end
         end
      end

      drain_results();
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
